[rtl/tmcbs_pkg.sv]
`timescale 1ns / 1ps

package tmcbs_pkg;

   // Format codes that bound the block-compressed range
   localparam logic [5:0] FmtFirstBlock = 6'd26;
   localparam logic [5:0] FmtLastBlock  = 6'd33;

   // Levels from this one on all share the same dimensions
   localparam logic [4:0] LastLevel = 5'd16;

   typedef struct packed {
      logic [5:0]  format_code;
      logic [7:0]  mip_count;
      logic [15:0] frame_count;
      logic [15:0] face_count;
      logic [15:0] base_width;
      logic [15:0] base_height;
      logic [15:0] slice_count;
   } req_type;

   typedef struct packed {
      logic [31:0] byte_length;
      logic        overflow;
   } rsp_type;

   // scale: bytes per pixel for plain formats, bytes per 4x4 block otherwise
   typedef struct packed {
      logic       block;
      logic [4:0] scale;
   } fmt_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BASE_SLICE,
      ST_BASE_FRAME,
      ST_BASE_FACE,
      ST_DIM,
      ST_TERM,
      ST_TAIL,
      ST_ACC,
      ST_DONE
   } state_type;

   function automatic fmt_type fmt_lookup(input logic [5:0] code);
      fmt_type f;
      f.block = (code >= FmtFirstBlock) && (code <= FmtLastBlock);
      case (code) inside
         6'd0:                             f.scale = 5'd16;
         6'd1:                             f.scale = 5'd12;
         6'd2, 6'd3:                       f.scale = 5'd8;
         [6'd4:6'd11]:                     f.scale = 5'd4;
         [6'd12:6'd16]:                    f.scale = 5'd3;
         [6'd17:6'd22]:                    f.scale = 5'd2;
         [6'd23:6'd25]:                    f.scale = 5'd1;
         [6'd26:6'd30]:                    f.scale = 5'd16;
         [6'd31:6'd33]:                    f.scale = 5'd8;
         default:                          f.scale = 5'd0;
      endcase
      return f;
   endfunction

endpackage

[rtl/texture_mip_chain_byte_size_top.sv]
// Texture mip chain byte size: one transaction on req_ carries a texture query and, later,
// one transaction on rsp_ returns the total byte length of all mip levels (modulo 2^32)
// with an overflow flag set when the exact total reaches 2^32. All products go through a
// single shared 32x32 multiplier under a small sequencer, so one query is worked on at a
// time and req_stall stays high until the query has been handed to the output register:
// the sequencer first sets up the per-level factor slices*scale*frames*faces, then works
// each mip level in turn (width*height, times factor, accumulate), for at most seventeen
// levels (sixteen distinct ones plus the constant tail level); when mip_count exceeds
// sixteen the tail level costs one extra multiply by the remaining count. The result is
// then loaded into the output register and the sequencer returns to idle, where it takes
// the next query.
// A finished result waits in its own register, so the next query is taken while the
// previous result is still stalled.
`timescale 1ns / 1ps

module texture_mip_chain_byte_size_top
   import tmcbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // sequencer and handshake
   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // latched query
   logic        block_ff, block_in;
   logic [4:0]  scale_ff, scale_in;
   logic [7:0]  mips_ff, mips_in;
   logic [15:0] slices_ff, slices_in;
   logic [15:0] frames_ff, frames_in;
   logic [15:0] faces_ff, faces_in;
   logic [15:0] w_ff, w_in;
   logic [15:0] h_ff, h_in;
   logic [4:0]  lvl_ff, lvl_in;

   // working values: base and term carry their low 32 bits and a flag for "2^32 or more"
   logic [31:0] base_lo_ff, base_lo_in;
   logic        base_big_ff, base_big_in;
   logic [31:0] dim_ff, dim_in;
   logic [31:0] term_lo_ff, term_lo_in;
   logic        term_big_ff, term_big_in;
   logic [31:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic        mul_a_big, mul_b_big;
   logic [63:0] mul_prod;
   logic        mul_zero, mul_big;

   fmt_type     fmt_info;
   logic [14:0] w_blk, h_blk;
   logic [15:0] dim_w, dim_h;
   logic [32:0] acc_sum;
   logic [4:0]  lvl_next;

   assign fmt_info = fmt_lookup(req_payload.format_code);

   // Exact low word of the product; the big flag tracks the full value since
   // every factor is non-negative: any zero factor forces a zero product.
   assign mul_prod = 64'(mul_a) * 64'(mul_b);
   assign mul_zero = ((mul_a == '0) && !mul_a_big) || ((mul_b == '0) && !mul_b_big);
   assign mul_big  = !mul_zero && (mul_a_big || mul_b_big || (mul_prod[63:32] != '0));

   // Level dimensions: block formats count 4x4 blocks, at least one per axis
   assign w_blk = 15'(({1'b0, w_ff} + 17'd3) >> 2);
   assign h_blk = 15'(({1'b0, h_ff} + 17'd3) >> 2);
   assign dim_w = !block_ff ? w_ff : ((w_blk == '0) ? 16'd1 : {1'b0, w_blk});
   assign dim_h = !block_ff ? h_ff : ((h_blk == '0) ? 16'd1 : {1'b0, h_blk});

   assign acc_sum  = {1'b0, acc_ff} + {1'b0, term_lo_ff};
   assign lvl_next = lvl_ff + 5'd1;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      block_in     = block_ff;
      scale_in     = scale_ff;
      mips_in      = mips_ff;
      slices_in    = slices_ff;
      frames_in    = frames_ff;
      faces_in     = faces_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      lvl_in       = lvl_ff;
      base_lo_in   = base_lo_ff;
      base_big_in  = base_big_ff;
      dim_in       = dim_ff;
      term_lo_in   = term_lo_ff;
      term_big_in  = term_big_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      mul_a        = '0;
      mul_b        = '0;
      mul_a_big    = 1'b0;
      mul_b_big    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // take a new query; the previous result may still be waiting
            if (req_valid) begin
               block_in  = fmt_info.block;
               scale_in  = fmt_info.scale;
               mips_in   = req_payload.mip_count;
               slices_in = req_payload.slice_count;
               frames_in = req_payload.frame_count;
               faces_in  = req_payload.face_count;
               w_in      = req_payload.base_width;
               h_in      = req_payload.base_height;
               lvl_in    = '0;
               acc_in    = '0;
               ovf_in    = 1'b0;
               state_in  = ST_BASE_SLICE;
            end
         end
         ST_BASE_SLICE: begin
            mul_a       = 32'(slices_ff);
            mul_b       = 32'(scale_ff);
            base_lo_in  = mul_prod[31:0];
            base_big_in = mul_big;
            state_in    = ST_BASE_FRAME;
         end
         ST_BASE_FRAME: begin
            mul_a       = base_lo_ff;
            mul_a_big   = base_big_ff;
            mul_b       = 32'(frames_ff);
            base_lo_in  = mul_prod[31:0];
            base_big_in = mul_big;
            state_in    = ST_BASE_FACE;
         end
         ST_BASE_FACE: begin
            mul_a       = base_lo_ff;
            mul_a_big   = base_big_ff;
            mul_b       = 32'(faces_ff);
            base_lo_in  = mul_prod[31:0];
            base_big_in = mul_big;
            state_in    = (mips_ff == '0) ? ST_DONE : ST_DIM;
         end
         ST_DIM: begin
            // pixels or blocks in one slice of this level, always below 2^32
            mul_a    = 32'(dim_w);
            mul_b    = 32'(dim_h);
            dim_in   = mul_prod[31:0];
            state_in = ST_TERM;
         end
         ST_TERM: begin
            mul_a       = dim_ff;
            mul_b       = base_lo_ff;
            mul_b_big   = base_big_ff;
            term_lo_in  = mul_prod[31:0];
            term_big_in = mul_big;
            state_in    = (lvl_ff == LastLevel) ? ST_TAIL : ST_ACC;
         end
         ST_TAIL: begin
            // every level from LastLevel onward is identical
            mul_a       = term_lo_ff;
            mul_a_big   = term_big_ff;
            mul_b       = 32'(mips_ff - 8'(LastLevel));
            term_lo_in  = mul_prod[31:0];
            term_big_in = mul_big;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_sum[31:0];
            ovf_in = ovf_ff || acc_sum[32] || term_big_ff;
            // halve each dimension, holding 1 and 0 where they are
            w_in   = (w_ff > 16'd1) ? (w_ff >> 1) : w_ff;
            h_in   = (h_ff > 16'd1) ? (h_ff >> 1) : h_ff;
            lvl_in = lvl_next;
            if ((8'(lvl_next) == mips_ff) || (lvl_ff == LastLevel)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIM;
            end
         end
         ST_DONE: begin
            // hold until the output register is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.byte_length = acc_ff;
               rsp_data_in.overflow    = ovf_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      block_ff    <= block_in;
      scale_ff    <= scale_in;
      mips_ff     <= mips_in;
      slices_ff   <= slices_in;
      frames_ff   <= frames_in;
      faces_ff    <= faces_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      lvl_ff      <= lvl_in;
      base_lo_ff  <= base_lo_in;
      base_big_ff <= base_big_in;
      dim_ff      <= dim_in;
      term_lo_ff  <= term_lo_in;
      term_big_ff <= term_big_in;
      acc_ff      <= acc_in;
      ovf_ff      <= ovf_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
